// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/cudr_pkg.sv =====
package cudr_pkg;

  localparam logic [7:0] MAX_DATA_BYTES = 8'd64;

  // byte positions inside a record
  localparam logic [3:0] STAMP_BYTES = 4'd8;
  localparam logic [3:0] LEN_POS     = 4'd12;
  localparam logic [3:0] DATA_POS    = 4'd13;

  localparam logic [7:0] DEST_UNSET  = 8'd255;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLEN = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_MSG  = 2'd0,
    KIND_REQ  = 2'd1,
    KIND_RESP = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       datagram_last;
  } word_t;

  typedef struct packed {
    logic [63:0] time_stamp;
    logic [28:0] frame_id;
    logic [2:0]  priority_level;
    kind_t       transfer_kind;
    logic        anonymous_flag;
    logic [12:0] port_number;
    logic [7:0]  dest_node;
    logic [6:0]  source_node;
    logic [7:0]  record_length;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        record_end;
  } result_t;

  // fill the header part of a result from the collected record header
  function automatic result_t hdr_decode(logic [63:0] stamp, logic [28:0] id,
                                         logic [7:0] len);
    result_t r;
    r                = '0;
    r.time_stamp     = stamp;
    r.frame_id       = id;
    r.priority_level = id[28:26];
    r.source_node    = id[6:0];
    r.record_length  = len;
    if (!id[25]) begin
      r.transfer_kind  = KIND_MSG;
      r.anonymous_flag = id[24];
      r.port_number    = id[20:8];
      r.dest_node      = DEST_UNSET;
    end else begin
      r.transfer_kind  = id[24] ? KIND_REQ : KIND_RESP;
      r.anonymous_flag = 1'b0;
      r.port_number    = {3'b000, id[23:14]};
      r.dest_node      = {1'b0, id[13:7]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cudr_in_if.sv =====
interface cudr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       datagram_last;

  modport source (output valid, output in_byte, output datagram_last, input ready);
  modport sink (input valid, input in_byte, input datagram_last, output ready);
endinterface

// ===== rtl/core/cudr_out_if.sv =====
interface cudr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] time_stamp;
  logic [28:0] frame_id;
  logic [2:0]  priority_level;
  logic [1:0]  transfer_kind;
  logic        anonymous_flag;
  logic [12:0] port_number;
  logic [7:0]  dest_node;
  logic [6:0]  source_node;
  logic [7:0]  record_length;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic        record_end;

  modport source (
    output valid, output time_stamp, output frame_id, output priority_level,
    output transfer_kind, output anonymous_flag, output port_number,
    output dest_node, output source_node, output record_length,
    output payload_byte, output status, output record_end, input ready
  );
  modport sink (
    input valid, input time_stamp, input frame_id, input priority_level,
    input transfer_kind, input anonymous_flag, input port_number,
    input dest_node, input source_node, input record_length,
    input payload_byte, input status, input record_end, output ready
  );
endinterface

// ===== rtl/core/cudr_in_stage.sv =====
module cudr_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cudr_pkg::word_t in_word,
  input  logic            advance,
  output logic            s1_valid,
  output cudr_pkg::word_t s1_word
);

  logic            valid_r;
  logic            valid_nxt;
  cudr_pkg::word_t word_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

// ===== rtl/core/cudr_parse.sv =====
module cudr_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  cudr_pkg::word_t   word,
  output logic              emit,
  output cudr_pkg::result_t result
);

  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [28:0] id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        skip_r, skip_nxt;
  logic        clear;

  always_comb begin
    pos_nxt   = pos_r;
    stamp_nxt = stamp_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    skip_nxt  = skip_r;
    clear     = 1'b0;
    emit      = 1'b0;
    result    = '0;
    if (skip_r) begin
      clear = word.datagram_last;
    end else if (pos_r < cudr_pkg::LEN_POS) begin
      if (pos_r < cudr_pkg::STAMP_BYTES) begin
        stamp_nxt = {stamp_r[55:0], word.in_byte};
      end else begin
        id_nxt = {id_r[20:0], word.in_byte};
      end
      pos_nxt = pos_r + 4'd1;
      if (word.datagram_last) begin
        // header cut short: only status and end are meaningful
        emit              = 1'b1;
        result.status     = cudr_pkg::ST_TRUNC;
        result.record_end = 1'b1;
        clear             = 1'b1;
      end
    end else if (pos_r == cudr_pkg::LEN_POS) begin
      len_nxt = word.in_byte;
      result  = cudr_pkg::hdr_decode(stamp_r, id_r, word.in_byte);
      result.record_end = 1'b1;
      if (word.in_byte > cudr_pkg::MAX_DATA_BYTES) begin
        emit          = 1'b1;
        result.status = cudr_pkg::ST_OVERLEN;
        if (word.datagram_last) begin
          clear = 1'b1;
        end else begin
          skip_nxt = 1'b1;
        end
      end else if (word.in_byte == 8'd0) begin
        emit  = 1'b1;
        clear = 1'b1;
      end else begin
        left_nxt = word.in_byte;
        pos_nxt  = cudr_pkg::DATA_POS;
        if (word.datagram_last) begin
          emit          = 1'b1;
          result.status = cudr_pkg::ST_TRUNC;
          clear         = 1'b1;
        end
      end
    end else begin
      emit                = 1'b1;
      result              = cudr_pkg::hdr_decode(stamp_r, id_r, len_r);
      result.payload_byte = word.in_byte;
      if (left_r <= 8'd1) begin
        result.record_end = 1'b1;
        clear             = 1'b1;
      end else begin
        left_nxt = left_r - 8'd1;
        if (word.datagram_last) begin
          result.status     = cudr_pkg::ST_TRUNC;
          result.record_end = 1'b1;
          clear             = 1'b1;
        end
      end
    end
    if (clear) begin
      pos_nxt   = '0;
      stamp_nxt = '0;
      id_nxt    = '0;
      len_nxt   = '0;
      left_nxt  = '0;
      skip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      stamp_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      left_r  <= '0;
      skip_r  <= 1'b0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      stamp_r <= stamp_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// ===== rtl/core/cudr_out_stage.sv =====
module cudr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cudr_pkg::result_t result,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output cudr_pkg::result_t out_result
);

  logic              valid_r;
  logic              valid_nxt;
  cudr_pkg::result_t result_r;

  // free when empty or the held word leaves this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== rtl/core/can_over_udp_record_deframer_top.sv =====
// channel   dir  handshake      word
// in_ch     in   valid/ready    in_byte, datagram_last
// out_ch    out  valid/ready    decoded record header, payload_byte, status, record_end
//
// one byte per cycle sustained while the receiver keeps up; a taken byte goes to the input register,
// and its decoded result is loaded into the result register once that register is free
// synchronous active-low reset clears record state and the valid flags of both registers
// a stalled result holds in the result register while one more byte waits at the input
`include "assert_macros.svh"

module can_over_udp_record_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  cudr_in_if.sink     in_ch,
  cudr_out_if.source  out_ch
);

  cudr_pkg::word_t   in_word;
  cudr_pkg::word_t   s1_word;
  cudr_pkg::result_t parse_result;
  cudr_pkg::result_t out_result;
  logic              s1_valid;
  logic              advance;
  logic              emit;
  logic              out_free;

  assign in_word.in_byte       = in_ch.in_byte;
  assign in_word.datagram_last = in_ch.datagram_last;

  // the decode step runs whenever a byte is held and the result register can take its word
  assign advance = s1_valid && out_free;

  cudr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_word),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  cudr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (s1_word),
    .emit    (emit),
    .result  (parse_result)
  );

  cudr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && emit),
    .result     (parse_result),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .free       (out_free),
    .out_result (out_result)
  );

  assign out_ch.time_stamp     = out_result.time_stamp;
  assign out_ch.frame_id       = out_result.frame_id;
  assign out_ch.priority_level = out_result.priority_level;
  assign out_ch.transfer_kind  = out_result.transfer_kind;
  assign out_ch.anonymous_flag = out_result.anonymous_flag;
  assign out_ch.port_number    = out_result.port_number;
  assign out_ch.dest_node      = out_result.dest_node;
  assign out_ch.source_node    = out_result.source_node;
  assign out_ch.record_length  = out_result.record_length;
  assign out_ch.payload_byte   = out_result.payload_byte;
  assign out_ch.status         = out_result.status;
  assign out_ch.record_end     = out_result.record_end;

  `ASSERT_CLK(a_err_ends_record,
    out_ch.valid && out_ch.status != cudr_pkg::ST_OK |-> out_ch.record_end,
    "error status without record end")
  `ASSERT_CLK(a_overlen_flagged,
    out_ch.valid && out_ch.record_length > cudr_pkg::MAX_DATA_BYTES
      |-> out_ch.status == cudr_pkg::ST_OVERLEN,
    "oversized length not flagged")
  `ASSERT_CLK(a_held_byte_kept,
    s1_valid && !advance |=> s1_valid && $stable(s1_word),
    "pending input byte lost")
  `ASSERT_NEVER(a_load_over_full,
    advance && emit && out_ch.valid && !out_ch.ready,
    "result register overwritten while stalled")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int ITEMS      = 900;
  localparam int LONG_HOLD  = 150;
  localparam int DRAIN_WAIT = 10;
  localparam int MAX_PRINTS = 40;

  // tracks the record parse and holds the results still owed by the block
  class record_tracker;
    cudr_pkg::result_t awaited[$];
    int                errors;
    int unsigned       pos;
    logic [63:0]       stamp;
    logic [31:0]       id_acc;
    logic [7:0]        len;
    logic [7:0]        left;
    bit                skipping;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos      = 0;
      stamp    = '0;
      id_acc   = '0;
      len      = '0;
      left     = '0;
      skipping = 1'b0;
    endfunction

    function void owe(cudr_pkg::result_t r);
      awaited.insert(awaited.size(), r);
    endfunction

    function cudr_pkg::result_t build(bit with_hdr, logic [7:0] data,
                                      cudr_pkg::status_t st, bit rec_end);
      cudr_pkg::result_t r;
      logic [28:0]       id;
      r  = '0;
      id = id_acc[28:0];
      if (with_hdr) begin
        r.time_stamp     = stamp;
        r.frame_id       = id;
        r.priority_level = id[28:26];
        r.source_node    = id[6:0];
        r.record_length  = len;
        if (id[25]) begin
          r.transfer_kind = id[24] ? cudr_pkg::KIND_REQ : cudr_pkg::KIND_RESP;
          r.port_number   = 13'(id[23:14]);
          r.dest_node     = 8'(id[13:7]);
        end else begin
          r.transfer_kind  = cudr_pkg::KIND_MSG;
          r.anonymous_flag = id[24];
          r.port_number    = id[20:8];
          r.dest_node      = cudr_pkg::DEST_UNSET;
        end
      end
      r.payload_byte = data;
      r.status       = st;
      r.record_end   = rec_end;
      return r;
    endfunction

    function void note_byte(cudr_pkg::word_t w);
      logic [7:0] b;
      bit         last;
      b    = w.in_byte;
      last = w.datagram_last;
      if (skipping) begin
        if (last) clear();
        return;
      end
      if (pos < cudr_pkg::LEN_POS) begin
        if (pos < cudr_pkg::STAMP_BYTES) stamp = {stamp[55:0], b};
        else id_acc = {id_acc[23:0], b};
        pos++;
        if (last) begin
          owe(build(1'b0, 8'd0, cudr_pkg::ST_TRUNC, 1'b1));
          clear();
        end
        return;
      end
      if (pos == cudr_pkg::LEN_POS) begin
        len = b;
        if (b > cudr_pkg::MAX_DATA_BYTES) begin
          owe(build(1'b1, 8'd0, cudr_pkg::ST_OVERLEN, 1'b1));
          if (last) clear();
          else skipping = 1'b1;
        end else if (b == 8'd0) begin
          owe(build(1'b1, 8'd0, cudr_pkg::ST_OK, 1'b1));
          clear();
        end else begin
          left = b;
          pos  = cudr_pkg::DATA_POS;
          if (last) begin
            owe(build(1'b1, 8'd0, cudr_pkg::ST_TRUNC, 1'b1));
            clear();
          end
        end
        return;
      end
      // data bytes
      if (left <= 8'd1) begin
        owe(build(1'b1, b, cudr_pkg::ST_OK, 1'b1));
        clear();
      end else begin
        left--;
        if (last) begin
          owe(build(1'b1, b, cudr_pkg::ST_TRUNC, 1'b1));
          clear();
        end else begin
          owe(build(1'b1, b, cudr_pkg::ST_OK, 1'b0));
        end
      end
    endfunction

    task report(string what, logic [63:0] got_v, logic [63:0] want_v);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got_v, want_v);
    endtask

    task check_result(cudr_pkg::result_t got);
      cudr_pkg::result_t want;
      if (awaited.size() == 0) begin
        report("result with nothing awaited", 64'(got.payload_byte), 64'd0);
        return;
      end
      want = awaited.pop_front();
      if (got.time_stamp !== want.time_stamp)
        report("time_stamp", got.time_stamp, want.time_stamp);
      if (got.frame_id !== want.frame_id)
        report("frame_id", 64'(got.frame_id), 64'(want.frame_id));
      if (got.priority_level !== want.priority_level)
        report("priority_level", 64'(got.priority_level), 64'(want.priority_level));
      if (got.transfer_kind !== want.transfer_kind)
        report("transfer_kind", 64'(got.transfer_kind), 64'(want.transfer_kind));
      if (got.anonymous_flag !== want.anonymous_flag)
        report("anonymous_flag", 64'(got.anonymous_flag), 64'(want.anonymous_flag));
      if (got.port_number !== want.port_number)
        report("port_number", 64'(got.port_number), 64'(want.port_number));
      if (got.dest_node !== want.dest_node)
        report("dest_node", 64'(got.dest_node), 64'(want.dest_node));
      if (got.source_node !== want.source_node)
        report("source_node", 64'(got.source_node), 64'(want.source_node));
      if (got.record_length !== want.record_length)
        report("record_length", 64'(got.record_length), 64'(want.record_length));
      if (got.payload_byte !== want.payload_byte)
        report("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.record_end !== want.record_end)
        report("record_end", 64'(got.record_end), 64'(want.record_end));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  record_tracker tracker;
  bit            hold_request;
  bit            gaps_on;
  int            burst_left;
  int unsigned   words_sent;

  cudr_in_if  in_ch();
  cudr_out_if out_ch();

  can_over_udp_record_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // watch both handshakes
  always @(posedge clk) begin
    cudr_pkg::word_t   taken;
    cudr_pkg::result_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken.in_byte       = in_ch.in_byte;
        taken.datagram_last = in_ch.datagram_last;
        tracker.note_byte(taken);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.time_stamp     = out_ch.time_stamp;
        seen.frame_id       = out_ch.frame_id;
        seen.priority_level = out_ch.priority_level;
        seen.transfer_kind  = cudr_pkg::kind_t'(out_ch.transfer_kind);
        seen.anonymous_flag = out_ch.anonymous_flag;
        seen.port_number    = out_ch.port_number;
        seen.dest_node      = out_ch.dest_node;
        seen.source_node    = out_ch.source_node;
        seen.record_length  = out_ch.record_length;
        seen.payload_byte   = out_ch.payload_byte;
        seen.status         = cudr_pkg::status_t'(out_ch.status);
        seen.record_end     = out_ch.record_end;
        tracker.check_result(seen);
      end
    end
  end

  // receiver: stretches of always ready, random stalls and heavy stalls
  initial begin
    int mode;
    int run_left;
    out_ch.ready <= 1'b0;
    mode     = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(4, 60);
      end
      run_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.datagram_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(1, 25);
      end
    end
  endtask

  task automatic send_datagram(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  function automatic void add_header(ref logic [7:0] q[$], input logic [63:0] ts,
                                     input logic [31:0] id, input logic [7:0] len);
    for (int i = 7; i >= 0; i--) q.insert(q.size(), ts[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) q.insert(q.size(), id[i*8 +: 8]);
    q.insert(q.size(), len);
  endfunction

  function automatic void add_record(ref logic [7:0] q[$], input logic [7:0] len);
    add_header(q, {$urandom, $urandom}, $urandom, len);
    if (len <= cudr_pkg::MAX_DATA_BYTES)
      repeat (len) q.insert(q.size(), 8'($urandom_range(0, 255)));
  endfunction

  // mostly short records, a few at the limit
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 75) return 8'($urandom_range(1, 8));
    if (r < 93) return 8'($urandom_range(9, cudr_pkg::MAX_DATA_BYTES - 1));
    return cudr_pkg::MAX_DATA_BYTES;
  endfunction

  initial begin
    logic [7:0] dg[$];
    int         pick;
    int         cut;
    bit         held;
    bit         paused;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= 8'd0;
    in_ch.datagram_last <= 1'b0;
    hold_request = 1'b0;
    gaps_on      = 1'b1;
    burst_left   = 10;
    words_sent   = 0;
    held         = 1'b0;
    paused       = 1'b0;
    tracker      = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // datagram of a single byte ends inside the header
    dg = {};
    dg.insert(dg.size(), 8'hA5);
    send_datagram(dg);
    // empty record with an all-ones header
    dg = {};
    add_header(dg, '1, '1, 8'd0);
    send_datagram(dg);
    // all-zero header, largest length, datagram ends on the length byte
    dg = {};
    add_header(dg, '0, '0, 8'hFF);
    send_datagram(dg);
    wait_drained();

    while (words_sent < ITEMS) begin
      if (!held && words_sent > 300) begin
        // receiver holds off while bytes keep coming back to back
        held         = 1'b1;
        hold_request = 1'b1;
        gaps_on      = 1'b0;
        dg = {};
        repeat (3) add_record(dg, 8'd20);
        send_datagram(dg);
        gaps_on = 1'b1;
      end
      if (!paused && words_sent > 600) begin
        paused = 1'b1;
        wait_drained();
      end
      dg   = {};
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 3)) add_record(dg, pick_len());
      end else if (pick < 70) begin
        // cut anywhere before the natural end
        repeat ($urandom_range(1, 3)) add_record(dg, pick_len());
        cut = $urandom_range(1, dg.size() - 1);
        dg  = dg[0:cut-1];
      end else if (pick < 75) begin
        // ends right on a nonzero legal length byte
        if ($urandom_range(0, 1)) add_record(dg, pick_len());
        add_header(dg, {$urandom, $urandom}, $urandom,
                   8'($urandom_range(1, cudr_pkg::MAX_DATA_BYTES)));
      end else if (pick < 87) begin
        // length over the limit, rest of the datagram is dropped
        if ($urandom_range(0, 1)) add_record(dg, pick_len());
        add_header(dg, {$urandom, $urandom}, $urandom,
                   8'($urandom_range(cudr_pkg::MAX_DATA_BYTES + 1, 255)));
        repeat ($urandom_range(0, 12)) dg.insert(dg.size(), 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 20)) dg.insert(dg.size(), 8'($urandom_range(0, 255)));
      end
      send_datagram(dg);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== can_over_udp_record_deframer_top.f =====
+incdir+rtl/core
rtl/core/cudr_pkg.sv
rtl/core/cudr_in_if.sv
rtl/core/cudr_out_if.sv
rtl/core/cudr_in_stage.sv
rtl/core/cudr_parse.sv
rtl/core/cudr_out_stage.sv
rtl/core/can_over_udp_record_deframer_top.sv
dv/tb.sv
